@@ sv/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tqle_pkg.sv @@
`timescale 1ns / 1ps

package tqle_pkg;

   // field widths
   localparam int STATE_W     = 10;
   localparam int ACTION_W    = 5;
   localparam int VALUE_W     = 32;
   localparam int FACTOR_W    = 17;
   localparam int CSR_INDEX_W = 1;

   // request beat layout (tdata), lowest bit first
   localparam int REQ_DATA_W     = 64;
   localparam int REQ_USER_W     = 1;
   localparam int REQ_ST_LSB     = 0;
   localparam int REQ_ACT_LSB    = 10;
   localparam int REQ_REWARD_LSB = 15;
   localparam int REQ_NST_LSB    = 47;
   localparam int REQ_NVALID_BIT = 57;

   // response beat layout (tdata)
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - ACTION_W - VALUE_W;

   // fixed point
   localparam int FRAC_W     = 16;
   localparam int ROUND_BIAS = 32768;
   localparam int GPROD_W    = 50;   // 32b value times 18b signed factor
   localparam int DELTA_W    = 35;
   localparam int APROD_W    = 53;   // 35b delta times 18b signed factor
   localparam int SUM_W      = 37;

   localparam logic [FACTOR_W-1:0] ONE_Q16     = 17'd65536;
   localparam logic [FACTOR_W-1:0] ALPHA_RESET = 17'd6554;
   localparam logic [FACTOR_W-1:0] GAMMA_RESET = 17'd58982;

   localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

   // operation codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic scan_issue;
      logic mul_g;
      logic delta;
      logic mul_a;
      logic write;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic is_query;
      logic st_ok;
      logic act_ok;
      logic next_ok;
   } dp_status_type;

endpackage

@@ sv/tqle_ram.sv @@
`timescale 1ns / 1ps

module tqle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/tqle_ctrl.sv @@
`timescale 1ns / 1ps

module tqle_ctrl import tqle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_CHECK    = 11'b000_0000_0100,
      S_SCAN     = 11'b000_0000_1000,
      S_SCAN_END = 11'b000_0001_0000,
      S_READ     = 11'b000_0010_0000,
      S_MUL_G    = 11'b000_0100_0000,
      S_DELTA    = 11'b000_1000_0000,
      S_MUL_A    = 11'b001_0000_0000,
      S_WRITE    = 11'b010_0000_0000,
      S_RESP     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // output slot can take a result this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // sequencing
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.is_query) begin
               state_in = status.st_ok ? S_SCAN : S_RESP;
            end else if (!(status.st_ok && status.act_ok)) begin
               state_in = S_RESP;
            end else begin
               state_in = status.next_ok ? S_SCAN : S_READ;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = status.is_query ? S_RESP : S_READ;
         end
         S_READ: begin
            state_in = S_MUL_G;
         end
         S_MUL_G: begin
            cmd.mul_g = 1'b1;
            state_in  = S_DELTA;
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_MUL_A;
         end
         S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ sv/tqle_datapath.sv @@
`timescale 1ns / 1ps

module tqle_datapath import tqle_pkg::*; #(
   parameter int STATE_COUNT       = 1024,
   parameter int ACTIONS_PER_STATE = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FACTOR_W-1:0]    csr_wdata,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int DEPTH  = STATE_COUNT * ACTIONS_PER_STATE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(ACTIONS_PER_STATE);

   // latched request fields
   logic                      op_ff;
   logic [STATE_W-1:0]        st_ff;
   logic [ACTION_W-1:0]       act_ff;
   logic signed [VALUE_W-1:0] reward_ff;
   logic [STATE_W-1:0]        nst_ff;
   logic                      nvalid_ff;
   logic [ADDR_W-1:0]         base_ff, base_in;
   logic [ADDR_W-1:0]         cur_addr_ff, cur_addr_in;

   // configuration
   logic [FACTOR_W-1:0] alpha_ff, gamma_ff;
   logic [FACTOR_W-1:0] a_eff, g_eff;

   // row scan
   logic [IDX_W-1:0]          scan_cnt_ff;
   logic                      cmp_vld_ff;
   logic [IDX_W-1:0]          cmp_idx_ff;
   logic signed [VALUE_W-1:0] best_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic                      take_max;

   // update arithmetic
   logic signed [VALUE_W-1:0] cur_ff;
   logic signed [GPROD_W-1:0] maxq_x, g_x, gprod_ff, gprod_in, gsum, gscaled;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [APROD_W-1:0] delta_x, a_x, aprod_ff, aprod_in, asum, ascaled;
   logic signed [SUM_W-1:0]   sum;
   logic signed [VALUE_W-1:0] q_sat;
   logic signed [VALUE_W-1:0] res_q_ff;

   // clearing pass
   logic [ADDR_W-1:0] clr_cnt_ff;

   // table memory
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [VALUE_W-1:0]  ram_wdata, ram_rdata;
   logic signed [VALUE_W-1:0] rd_q;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATE_W-1:0]    req_st, req_nst, row_sel;
   logic [ACTION_W-1:0]   req_act;

   tqle_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // request fields and row addresses
   assign req_st  = req_tdata[REQ_ST_LSB +: STATE_W];
   assign req_act = req_tdata[REQ_ACT_LSB +: ACTION_W];
   assign req_nst = req_tdata[REQ_NST_LSB +: STATE_W];
   assign row_sel = (req_tuser[0] == OP_QUERY) ? req_st : req_nst;
   assign base_in = ADDR_W'(32'(row_sel) * 32'(ACTIONS_PER_STATE));
   assign cur_addr_in = ADDR_W'(32'(req_st) * 32'(ACTIONS_PER_STATE) + 32'(req_act));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_tuser[0];
         st_ff       <= req_st;
         act_ff      <= req_act;
         reward_ff   <= $signed(req_tdata[REQ_REWARD_LSB +: VALUE_W]);
         nst_ff      <= req_nst;
         nvalid_ff   <= req_tdata[REQ_NVALID_BIT];
         base_ff     <= base_in;
         cur_addr_ff <= cur_addr_in;
      end
   end

   // range checks and scan/clear status for the controller
   assign status.is_query   = (op_ff == OP_QUERY);
   assign status.st_ok      = 32'(st_ff) < 32'(STATE_COUNT);
   assign status.act_ok     = 32'(act_ff) < 32'(ACTIONS_PER_STATE);
   assign status.next_ok    = nvalid_ff && (32'(nst_ff) < 32'(STATE_COUNT));
   assign status.scan_last  = (scan_cnt_ff == IDX_W'(ACTIONS_PER_STATE - 1));
   assign status.clear_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         gamma_ff <= GAMMA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata;
            CSR_GAMMA: gamma_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // factors above one act as one
   assign a_eff = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign g_eff = (gamma_ff > ONE_Q16) ? ONE_Q16 : gamma_ff;

   // memory ports
   assign ram_raddr = cmd.scan_issue ? base_ff + ADDR_W'(scan_cnt_ff) : cur_addr_ff;
   assign ram_we    = cmd.clear || cmd.write;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : cur_addr_ff;
   assign ram_wdata = cmd.clear ? '0 : q_sat;
   assign rd_q      = $signed(ram_rdata);

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // scan: issue one address a cycle, compare in the next cycle when the registered read returns
   assign take_max = cmp_vld_ff && ((cmp_idx_ff == '0) || (rd_q > best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_cnt_ff;
      if (cmd.load) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
      end
      if (cmd.load) begin
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else if (take_max) begin
         best_ff     <= rd_q;
         best_idx_ff <= cmp_idx_ff;
      end
   end

   // gamma times next-state max
   assign maxq_x   = {{(GPROD_W - VALUE_W){best_ff[VALUE_W-1]}}, best_ff};
   assign g_x      = $signed({{(GPROD_W - FACTOR_W){1'b0}}, g_eff});
   assign gprod_in = maxq_x * g_x;

   // delta = reward + round(gamma * maxq) - q
   assign gsum     = gprod_ff + $signed(GPROD_W'(ROUND_BIAS));
   assign gscaled  = gsum >>> FRAC_W;
   assign delta_in = DELTA_W'(reward_ff) + DELTA_W'(gscaled) - DELTA_W'(cur_ff);

   // alpha times delta
   assign delta_x  = APROD_W'(delta_ff);
   assign a_x      = $signed({{(APROD_W - FACTOR_W){1'b0}}, a_eff});
   assign aprod_in = delta_x * a_x;

   // new q with saturation
   assign asum    = aprod_ff + $signed(APROD_W'(ROUND_BIAS));
   assign ascaled = asum >>> FRAC_W;
   assign sum     = SUM_W'(cur_ff) + SUM_W'(ascaled);

   always_comb begin
      if ((sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1)) begin
         q_sat = sum[VALUE_W-1:0];
      end else begin
         q_sat = sum[SUM_W-1] ? Q_MIN : Q_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_g) begin
         cur_ff   <= rd_q;
         gprod_ff <= gprod_in;
      end
      if (cmd.delta) begin
         delta_ff <= delta_in;
      end
      if (cmd.mul_a) begin
         aprod_ff <= aprod_in;
      end
      if (cmd.load) begin
         res_q_ff <= '0;
      end else if (cmd.write) begin
         res_q_ff <= q_sat;
      end
   end

   // response payload
   always_comb begin
      if (op_ff == OP_QUERY) begin
         rsp_data_in = {{RSP_PAD_W{1'b0}}, best_ff, ACTION_W'(best_idx_ff)};
      end else begin
         rsp_data_in = {{RSP_PAD_W{1'b0}}, res_q_ff, act_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

@@ sv/tabular_q_learning_engine.sv @@
`timescale 1ns / 1ps

// Tabular Q-learning engine. Holds a Q16.16 table of STATE_COUNT x ACTIONS_PER_STATE
// entries in one single-port-write, registered-read RAM. After reset the block
// runs a clearing pass that writes zero to every entry, one entry a cycle;
// req_tready stays low until it ends, while register writes are taken throughout.
// Items are worked one at a time. A greedy query scans the state's row through
// the RAM read port; an update with a valid next state scans that row, then
// reads, computes and writes back the entry with two registered multiplies.
// Updates without a valid next state skip the scan, and out-of-range items
// return at once. A finished result waits in an output register, so the next
// request beat is accepted while the previous response is still stalled.
module tabular_q_learning_engine import tqle_pkg::*; #(
   parameter int STATE_COUNT       = 1024,
   parameter int ACTIONS_PER_STATE = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // state_index[9:0], action_index[14:10], reward[46:15],
   // next_state_index[56:47], next_state_valid[57], zero[63:58]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // operation[0]
   input  logic [REQ_USER_W-1:0]  req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // chosen_action[4:0], q_value[36:5], zero[39:37]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FACTOR_W-1:0]    csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   tqle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // table, scan and arithmetic
   tqle_datapath #(
      .STATE_COUNT       (STATE_COUNT),
      .ACTIONS_PER_STATE (ACTIONS_PER_STATE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ sv/tqle_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tqle_checker import tqle_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // items accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response valid dropped while stalled")
   `ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "response beat changed while stalled")
   `ASSERT_IMPLIES(a_no_spurious_rsp, clock, reset, rsp_tvalid, pending_ff != 2'd0, "response with no item outstanding")
   `ASSERT_IMPLIES(a_one_in_flight, clock, reset, pending_ff == 2'd2, !req_tready, "request taken with two items outstanding")

endmodule

bind tabular_q_learning_engine tqle_checker u_checker (.*);
